/* hdl/jjj_pkg.sv */
// shared types and constants of the joystick joint jog controller
`timescale 1ns / 1ps
package jjj_pkg;

	localparam int NUM_JOINTS = 6;
	localparam int NUM_STICKS = 3;
	localparam int STICK_W = 10;
	localparam int SPEED_W = 16;
	localparam int ANGLE_W = 32;
	localparam int EXC_W = STICK_W + 1;
	localparam int PROD_W = EXC_W + SPEED_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int JIDX_W = 3;

	localparam logic [STICK_W-1:0] DEADBAND_LOW_RST = 10'd480;
	localparam logic [STICK_W-1:0] DEADBAND_HIGH_RST = 10'd544;
	localparam logic [SPEED_W-1:0] SPEED_MAX_RST = 16'd1024;
	localparam logic [SPEED_W-1:0] SPEED_MIN_RST = 16'd102;
	localparam logic [SPEED_W-1:0] SPEED_STEP_RST = 16'd102;
	localparam logic [SPEED_W-1:0] SPEED_RST = 16'd512;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

	// button bits, active low
	localparam int BTN_UP = 0;
	localparam int BTN_DOWN = 1;
	localparam int BTN_GRIP_ON = 2;
	localparam int BTN_GRIP_OFF = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADBAND_LOW  = 3'd0,
		CFG_DEADBAND_HIGH = 3'd1,
		CFG_SPEED_MAX     = 3'd2,
		CFG_SPEED_MIN     = 3'd3,
		CFG_SPEED_STEP    = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_LIMITS = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                      cmd;
		logic [STICK_W-1:0]        stick_x_left;
		logic [STICK_W-1:0]        stick_y_left;
		logic [STICK_W-1:0]        stick_y_right;
		logic                      joint_mode;
		logic                      wrist_group;
		logic [3:0]                buttons_n;
		logic [JIDX_W-1:0]         joint_index;
		logic signed [ANGLE_W-1:0] limit_low;
		logic signed [ANGLE_W-1:0] limit_high;
	} in_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] joint_0;
		logic signed [ANGLE_W-1:0] joint_1;
		logic signed [ANGLE_W-1:0] joint_2;
		logic signed [ANGLE_W-1:0] joint_3;
		logic signed [ANGLE_W-1:0] joint_4;
		logic signed [ANGLE_W-1:0] joint_5;
		logic                      grip_closed;
		logic                      limit_hit;
		logic [SPEED_W-1:0]        speed_now;
	} out_item_t;

	// control of one stick lane
	typedef struct packed {
		logic take;
		logic calc;
	} lane_ctl_t;

	// control of one joint lane at commit
	typedef struct packed {
		logic                      commit;
		logic                      jog;
		logic                      load;
		logic signed [ANGLE_W-1:0] limit_low;
		logic signed [ANGLE_W-1:0] limit_high;
	} joint_ctl_t;

endpackage

/* hdl/jjj_if.sv */
// valid/ready channel interfaces for joystick items and results
`timescale 1ns / 1ps
interface jjj_in_if;
	import jjj_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface jjj_out_if;
	import jjj_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hdl/joystick_joint_jog_controller_unit.sv */
// Joystick joint jog controller. Takes one item per cycle back to back while
// the output does not stall and gives one result per item through stage one,
// stage two and the commit stage: stage one takes the speed buttons and grip
// and registers the stick deadband excess, stage two multiplies the excess by
// the jog speed in three stick lanes, and the commit stage adds, saturates and
// clamps all six joints in parallel lanes into the output register. Limit
// loads (cmd 1) pass through the same stages. A stalled output holds the
// result while up to two more items continue to flow into the pipeline.
`timescale 1ns / 1ps
module joystick_joint_jog_controller_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	jjj_in_if.sink                             in_ch,
	jjj_out_if.source                          out_ch,
	input  logic                               cfg_we,
	input  logic [jjj_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jjj_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import jjj_pkg::*;

	// configuration
	logic [STICK_W-1:0] deadband_low_q;
	logic [STICK_W-1:0] deadband_high_q;
	logic [SPEED_W-1:0] speed_max_q;
	logic [SPEED_W-1:0] speed_min_q;
	logic [SPEED_W-1:0] speed_step_q;

	// kept state
	logic [SPEED_W-1:0] speed_q;
	logic               up_armed_q;
	logic               down_armed_q;
	logic               grip_q;
	logic               clamp_flag_q;

	// pipeline control
	logic v1_q, v2_q, out_valid_q;
	logic accept, adv2, commit;

	// stage payload
	logic                      cmd_s1, cmd_s2;
	logic                      mode_s1, mode_s2;
	logic                      wrist_s1, wrist_s2;
	logic [JIDX_W-1:0]         jidx_s1, jidx_s2;
	logic signed [ANGLE_W-1:0] lim_lo_s1, lim_lo_s2;
	logic signed [ANGLE_W-1:0] lim_hi_s1, lim_hi_s2;
	logic [SPEED_W-1:0]        speed_s1, speed_s2;
	logic                      grip_s1, grip_s2;

	logic [SPEED_W:0]   up_sum;
	logic [SPEED_W-1:0] sp_up;
	logic [SPEED_W-1:0] sp_dn;
	logic [SPEED_W-1:0] dn_diff;
	logic               grip_next;
	logic               is_sample;

	lane_ctl_t                 lane_ctl;
	logic [STICK_W-1:0]        sticks [NUM_STICKS];
	logic signed [PROD_W-1:0]  prod_s2 [NUM_STICKS];
	logic signed [ANGLE_W-1:0] angle_next [NUM_JOINTS];
	logic [NUM_JOINTS-1:0]     hits;
	logic                      jog_now;
	out_item_t                 out_q;

	assign commit = v2_q && (!out_valid_q || out_ch.ready);
	assign adv2 = v1_q && (!v2_q || commit);
	assign in_ch.ready = !v1_q || adv2;
	assign accept = in_ch.valid && in_ch.ready;
	assign is_sample = (in_ch.data.cmd == CMD_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_low_q <= DEADBAND_LOW_RST;
			deadband_high_q <= DEADBAND_HIGH_RST;
			speed_max_q <= SPEED_MAX_RST;
			speed_min_q <= SPEED_MIN_RST;
			speed_step_q <= SPEED_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEADBAND_LOW: deadband_low_q <= cfg_data[STICK_W-1:0];
				CFG_DEADBAND_HIGH: deadband_high_q <= cfg_data[STICK_W-1:0];
				CFG_SPEED_MAX: speed_max_q <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_MIN: speed_min_q <= cfg_data[SPEED_W-1:0];
				CFG_SPEED_STEP: speed_step_q <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// speed up is applied before speed down
	always_comb begin
		up_sum = {1'b0, speed_q} + {1'b0, speed_step_q};
		if (!in_ch.data.buttons_n[BTN_UP] && up_armed_q) begin
			sp_up = (up_sum > {1'b0, speed_max_q}) ? speed_max_q : up_sum[SPEED_W-1:0];
		end else begin
			sp_up = speed_q;
		end
		dn_diff = sp_up - speed_step_q;
		if (!in_ch.data.buttons_n[BTN_DOWN] && down_armed_q) begin
			sp_dn = (sp_up >= speed_step_q && dn_diff >= speed_min_q) ? dn_diff
				: speed_min_q;
		end else begin
			sp_dn = sp_up;
		end
		if (!in_ch.data.buttons_n[BTN_GRIP_OFF]) begin
			grip_next = 1'b0;
		end else if (!in_ch.data.buttons_n[BTN_GRIP_ON]) begin
			grip_next = 1'b1;
		end else begin
			grip_next = grip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RST;
			up_armed_q <= 1'b1;
			down_armed_q <= 1'b1;
			grip_q <= 1'b0;
		end else if (accept && is_sample) begin
			speed_q <= sp_dn;
			up_armed_q <= in_ch.data.buttons_n[BTN_UP];
			down_armed_q <= in_ch.data.buttons_n[BTN_DOWN];
			grip_q <= grip_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v1_q <= 1'b1;
			end else if (adv2) begin
				v1_q <= 1'b0;
			end
			if (adv2) begin
				v2_q <= 1'b1;
			end else if (commit) begin
				v2_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= in_ch.data.cmd;
			mode_s1 <= in_ch.data.joint_mode;
			wrist_s1 <= in_ch.data.wrist_group;
			jidx_s1 <= in_ch.data.joint_index;
			lim_lo_s1 <= in_ch.data.limit_low;
			lim_hi_s1 <= in_ch.data.limit_high;
			speed_s1 <= is_sample ? sp_dn : speed_q;
			grip_s1 <= is_sample ? grip_next : grip_q;
		end
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			mode_s2 <= mode_s1;
			wrist_s2 <= wrist_s1;
			jidx_s2 <= jidx_s1;
			lim_lo_s2 <= lim_lo_s1;
			lim_hi_s2 <= lim_hi_s1;
			speed_s2 <= speed_s1;
			grip_s2 <= grip_s1;
		end
	end

	assign lane_ctl.take = accept;
	assign lane_ctl.calc = adv2;
	assign sticks[0] = in_ch.data.stick_x_left;
	assign sticks[1] = in_ch.data.stick_y_left;
	assign sticks[2] = in_ch.data.stick_y_right;

	for (genvar k = 0; k < NUM_STICKS; k++) begin : g_stick
		jjj_stick_lane u_stick (
			.clk          (clk),
			.ctl          (lane_ctl),
			.stick        (sticks[k]),
			.deadband_low (deadband_low_q),
			.deadband_high(deadband_high_q),
			.speed        (speed_s1),
			.product      (prod_s2[k])
		);
	end

	assign jog_now = (cmd_s2 == CMD_SAMPLE) && mode_s2;

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
		localparam int LANE = j % NUM_STICKS;
		localparam logic GROUP = (j >= NUM_STICKS);
		joint_ctl_t               jctl;
		logic signed [PROD_W-1:0] prod_sel;

		// joints outside the selected group still get clamped
		assign prod_sel = (wrist_s2 == GROUP) ? prod_s2[LANE] : '0;
		assign jctl.commit = commit;
		assign jctl.jog = jog_now;
		assign jctl.load = (cmd_s2 == CMD_LIMITS) && (jidx_s2 == JIDX_W'(j));
		assign jctl.limit_low = lim_lo_s2;
		assign jctl.limit_high = lim_hi_s2;

		jjj_joint_lane u_joint (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (jctl),
			.product   (prod_sel),
			.angle_next(angle_next[j]),
			.hit       (hits[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_flag_q <= 1'b0;
		end else if (commit && jog_now) begin
			clamp_flag_q <= |hits;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.joint_0 <= angle_next[0];
			out_q.joint_1 <= angle_next[1];
			out_q.joint_2 <= angle_next[2];
			out_q.joint_3 <= angle_next[3];
			out_q.joint_4 <= angle_next[4];
			out_q.joint_5 <= angle_next[5];
			out_q.grip_closed <= grip_s2;
			out_q.limit_hit <= jog_now ? (|hits) : clamp_flag_q;
			out_q.speed_now <= speed_s2;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

`ifndef SYNTH
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v1_q)
		else $error("accepted transaction did not reach stage one");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_ch.valid)
		else $error("committed transaction did not show a result");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !out_ch.valid) |-> commit)
		else $error("stage two held with an empty output register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> in_ch.ready)
		else $error("input not ready with stage one empty");
`endif

endmodule

/* hdl/jjj_stick_lane.sv */
// one stick lane: deadband excess, then excess times speed
`timescale 1ns / 1ps
module jjj_stick_lane (
	input  logic                                 clk,
	input  jjj_pkg::lane_ctl_t                   ctl,
	input  logic [jjj_pkg::STICK_W-1:0]          stick,
	input  logic [jjj_pkg::STICK_W-1:0]          deadband_low,
	input  logic [jjj_pkg::STICK_W-1:0]          deadband_high,
	input  logic [jjj_pkg::SPEED_W-1:0]          speed,
	output logic signed [jjj_pkg::PROD_W-1:0]    product
);
	import jjj_pkg::*;

	logic signed [EXC_W-1:0]  excess;
	logic signed [EXC_W-1:0]  excess_s1;
	logic signed [PROD_W-1:0] product_s2;

	always_comb begin
		if (stick < deadband_low) begin
			excess = signed'({1'b0, stick}) - signed'({1'b0, deadband_low});
		end else if (stick > deadband_high) begin
			excess = signed'({1'b0, stick}) - signed'({1'b0, deadband_high});
		end else begin
			excess = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			excess_s1 <= excess;
		end
		if (ctl.calc) begin
			product_s2 <= PROD_W'(excess_s1 * signed'({1'b0, speed}));
		end
	end

	assign product = product_s2;

endmodule

/* hdl/jjj_joint_lane.sv */
// one joint lane: angle and limit registers, saturating add and clamp
`timescale 1ns / 1ps
module jjj_joint_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  jjj_pkg::joint_ctl_t                  ctl,
	input  logic signed [jjj_pkg::PROD_W-1:0]    product,
	output logic signed [jjj_pkg::ANGLE_W-1:0]   angle_next,
	output logic                                 hit
);
	import jjj_pkg::*;

	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [ANGLE_W-1:0] min_q;
	logic signed [ANGLE_W-1:0] max_q;
	logic signed [ANGLE_W:0]   sum;
	logic signed [ANGLE_W-1:0] sat;
	logic signed [ANGLE_W-1:0] clamped;
	logic                      clamp_hit;

	always_comb begin
		sum = {angle_q[ANGLE_W-1], angle_q} + (ANGLE_W + 1)'(product);
		// overflow when the two top bits disagree
		if (sum[ANGLE_W] != sum[ANGLE_W-1]) begin
			sat = sum[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
		end else begin
			sat = sum[ANGLE_W-1:0];
		end
		clamp_hit = 1'b1;
		if (sat < min_q) begin
			clamped = min_q;
		end else if (sat > max_q) begin
			clamped = max_q;
		end else begin
			clamped = sat;
			clamp_hit = 1'b0;
		end
		angle_next = ctl.jog ? clamped : angle_q;
		hit = ctl.jog && clamp_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			min_q <= ANGLE_MIN;
			max_q <= ANGLE_MAX;
		end else if (ctl.commit) begin
			angle_q <= angle_next;
			if (ctl.load) begin
				min_q <= ctl.limit_low;
				max_q <= ctl.limit_high;
			end
		end
	end

endmodule
